[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl of the keyed siphash tag block
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SIPT_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SIPT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SIPT_ASSERT(lbl, clk, rstn, prop, msg)
`define SIPT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

[rtl/core/sipt_pkg.sv]
// types, constants and key derivation for the keyed siphash tag block
// no dependencies
package sipt_pkg;

	localparam logic [63:0] KEY_C0    = 64'hED9DE0801B44BE27;
	localparam logic [63:0] KEY_C1    = 64'h485B6527237AB93A;
	localparam logic [63:0] IV0       = 64'h736f6d6570736575;
	localparam logic [63:0] IV1       = 64'h646f72616e646f6d;
	localparam logic [63:0] IV2       = 64'h6c7967656e657261;
	localparam logic [63:0] IV3       = 64'h7465646279746573;
	localparam logic [31:0] FOLD_M1   = 32'h7feb352d;
	localparam logic [31:0] FOLD_M2   = 32'h846ca68b;
	localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

	typedef logic [3:0][63:0] lanes_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_LAUNCH,
		ST_FOLD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_MSG,
		PH_TAIL,
		PH_FINAL
	} phase_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_MUL1,
		FS_MUL2
	} fold_state_t;

	typedef struct packed {
		logic start;
	} fold_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} fold_sts_t;

	function automatic lanes_t key_lanes(input logic [31:0] nonce);
		logic [63:0] s;
		logic [63:0] k0;
		logic [63:0] k1;
		lanes_t l;
		s  = {nonce, nonce};
		k0 = KEY_C0 ^ s;
		k1 = KEY_C1 ^ {s[46:0], s[63:47]};
		l[0] = IV0 ^ k0;
		l[1] = IV1 ^ k1;
		l[2] = IV2 ^ k0;
		l[3] = IV3 ^ k1;
		return l;
	endfunction

endpackage

[rtl/core/sipt_channels.sv]
// handshake channel interfaces of the keyed siphash tag block
// no dependencies
interface sipt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       last;
	modport source (output valid, output data_byte, output byte_valid, output last,
		input ready);
	modport sink (input valid, input data_byte, input byte_valid, input last,
		output ready);
endinterface

interface sipt_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] tag;
	modport source (output valid, output tag, input ready);
	modport sink (input valid, input tag, output ready);
endinterface

interface sipt_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] session_nonce;
	modport source (output valid, output session_nonce, input ready);
	modport sink (input valid, input session_nonce, output ready);
endinterface

[rtl/core/sipt_half_round.sv]
// one half of a siphash round, selected by sel; the shared lane mixer
// depends on sipt_pkg
module sipt_half_round (
	input  sipt_pkg::lanes_t lanes_in,
	input  logic             sel,
	output sipt_pkg::lanes_t lanes_out
);

	logic [63:0] a;
	logic [63:0] b;
	logic [63:0] c;
	logic [63:0] d;
	logic [63:0] sum_a;
	logic [63:0] sum_c;

	always_comb begin
		a = lanes_in[0];
		b = lanes_in[1];
		c = lanes_in[2];
		d = lanes_in[3];
		if (!sel) begin
			sum_a = a + b;
			sum_c = c + d;
			lanes_out[0] = {sum_a[31:0], sum_a[63:32]};
			lanes_out[1] = {b[50:0], b[63:51]} ^ sum_a;
			lanes_out[2] = sum_c;
			lanes_out[3] = {d[47:0], d[63:48]} ^ sum_c;
		end else begin
			sum_a = a + d;
			sum_c = c + b;
			lanes_out[0] = sum_a;
			lanes_out[1] = {b[46:0], b[63:47]} ^ sum_c;
			lanes_out[2] = {sum_c[31:0], sum_c[63:32]};
			lanes_out[3] = {d[42:0], d[63:43]} ^ sum_a;
		end
	end

endmodule

[rtl/core/sipt_fold.sv]
// folds the 64-bit lane xor to a 32-bit tag with one shared multiplier
// depends on sipt_pkg
module sipt_fold (
	input  logic                clk,
	input  logic                arst_n,
	input  sipt_pkg::fold_ctl_t ctl,
	input  sipt_pkg::lanes_t    lanes,
	output sipt_pkg::fold_sts_t sts,
	output logic [31:0]         tag
);

	sipt_pkg::fold_state_t state_q;
	sipt_pkg::fold_state_t state_d;
	logic [31:0] f_q;
	logic [31:0] f_d;
	logic        done_q;
	logic        done_d;
	logic [63:0] h;
	logic [31:0] f0;
	logic [31:0] mul_k;
	logic [31:0] prod;

	assign h     = lanes[0] ^ lanes[1] ^ lanes[2] ^ lanes[3];
	assign f0    = h[31:0] ^ h[63:32];
	assign mul_k = (state_q == sipt_pkg::FS_MUL1) ? sipt_pkg::FOLD_M1 : sipt_pkg::FOLD_M2;
	assign prod  = f_q * mul_k;

	always_comb begin
		state_d = state_q;
		f_d     = f_q;
		done_d  = 1'b0;
		unique case (state_q)
			sipt_pkg::FS_IDLE: begin
				if (ctl.start) begin
					f_d     = f0 ^ (f0 >> 16);
					state_d = sipt_pkg::FS_MUL1;
				end
			end
			sipt_pkg::FS_MUL1: begin
				f_d     = prod ^ (prod >> 15);
				state_d = sipt_pkg::FS_MUL2;
			end
			sipt_pkg::FS_MUL2: begin
				f_d     = prod ^ (prod >> 16);
				done_d  = 1'b1;
				state_d = sipt_pkg::FS_IDLE;
			end
			default: begin
				state_d = sipt_pkg::FS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sipt_pkg::FS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		f_q <= f_d;
	end

	assign sts.busy = (state_q != sipt_pkg::FS_IDLE);
	assign sts.done = done_q;
	assign tag      = f_q;

endmodule

[rtl/core/keyed_siphash_tag32.sv]
// keyed siphash-2-4 tag generator, top level with sequencer and lane registers
// depends on sipt_pkg, sipt_channels, sipt_half_round, sipt_fold, assert_macros.svh
//
// usage:
//   cfg carries the 32-bit session nonce; it is always ready. The user must
//   write it only between messages; the block does not enforce this. The key
//   is taken from it when a message starts. item carries one word per
//   message byte (data_byte, byte_valid, last). A word with byte_valid and
//   last both low is dropped; last with byte_valid low closes the message
//   without a byte, so an empty message can be tagged.
//   result carries the 32-bit tag, one word per message.
// sequence:
//   a byte that does not complete an 8-byte block is stored; the sequencer stays idle.
//   a byte that completes a block runs 4 half-round passes.
//   a last word runs to the tag register through an optional block,
//   tail block and four closing rounds, all through the single half-round
//   mixer, then starts the fold, runs two steps through one 32x32
//   multiplier, sees it done and loads the tag.
// reset clears the sequencer, the byte count and the result valid flag; the
// nonce resets to zero. item.ready is low while the sequencer works. A new
// message may be accepted while a tag waits in the result register; its own
// tag is held back until the receiver has taken the previous one.
`include "assert_macros.svh"

module keyed_siphash_tag32 (
	input logic        clk,
	input logic        arst_n,
	sipt_in_if.sink    item,
	sipt_out_if.source result,
	sipt_cfg_if.sink   cfg
);

	sipt_pkg::state_t  state_q;
	sipt_pkg::state_t  state_d;
	sipt_pkg::phase_t  phase_q;
	sipt_pkg::phase_t  phase_d;
	logic [2:0]        hr_q;
	logic [2:0]        hr_d;
	logic              fin_q;
	logic              fin_d;
	sipt_pkg::lanes_t  lanes_q;
	sipt_pkg::lanes_t  lanes_d;
	logic [63:0]       word_q;
	logic [63:0]       word_d;
	logic [55:0]       pw_q;
	logic [55:0]       pw_d;
	logic [7:0]        cnt_q;
	logic [7:0]        cnt_d;
	logic              in_msg_q;
	logic              in_msg_d;
	logic [31:0]       nonce_q;
	logic [31:0]       tag_q;
	logic              out_vld_q;
	logic              load_out;

	sipt_pkg::lanes_t    lanes_base;
	sipt_pkg::lanes_t    hr_out;
	logic [55:0]         pw_base;
	logic [55:0]         pw_add;
	logic [7:0]          cnt_base;
	logic [7:0]          cnt_add;
	logic [2:0]          pos;
	logic                full;
	logic [63:0]         full_word;
	logic [63:0]         tail_word;
	logic [2:0]          hr_end;
	logic                acc;
	sipt_pkg::fold_ctl_t fold_ctl;
	sipt_pkg::fold_sts_t fold_sts;
	logic [31:0]         fold_tag;

	sipt_half_round u_round (
		.lanes_in  (lanes_q),
		.sel       (hr_q[0]),
		.lanes_out (hr_out)
	);

	sipt_fold u_fold (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fold_ctl),
		.lanes  (lanes_q),
		.sts    (fold_sts),
		.tag    (fold_tag)
	);

	assign item.ready = (state_q == sipt_pkg::ST_IDLE);
	assign acc        = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	// message state as seen by the incoming word
	assign lanes_base = in_msg_q ? lanes_q : sipt_pkg::key_lanes(nonce_q);
	assign pw_base    = in_msg_q ? pw_q : 56'd0;
	assign cnt_base   = in_msg_q ? cnt_q : 8'd0;
	assign pos        = cnt_base[2:0];
	assign full       = item.byte_valid && (pos == 3'd7);
	assign cnt_add    = item.byte_valid ? cnt_base + 8'd1 : cnt_base;
	assign full_word  = {item.data_byte, pw_base};
	assign tail_word  = {cnt_add, pw_add};
	assign hr_end     = (phase_q == sipt_pkg::PH_FINAL) ? 3'd7 : 3'd3;

	always_comb begin
		for (int i = 0; i < 7; i++) begin
			pw_add[8*i +: 8] = (item.byte_valid && pos == 3'(i)) ? item.data_byte
				: pw_base[8*i +: 8];
		end
	end

	always_comb begin
		state_d        = state_q;
		phase_d        = phase_q;
		hr_d           = hr_q;
		fin_d          = fin_q;
		lanes_d        = lanes_q;
		word_d         = word_q;
		pw_d           = pw_q;
		cnt_d          = cnt_q;
		in_msg_d       = in_msg_q;
		fold_ctl.start = 1'b0;
		load_out       = 1'b0;
		unique case (state_q)
			sipt_pkg::ST_IDLE: begin
				if (acc && (item.byte_valid || item.last)) begin
					lanes_d  = lanes_base;
					pw_d     = pw_add;
					cnt_d    = cnt_add;
					in_msg_d = !item.last;
					hr_d     = 3'd0;
					fin_d    = item.last;
					if (full) begin
						lanes_d[3] = lanes_base[3] ^ full_word;
						word_d     = full_word;
						pw_d       = 56'd0;
						phase_d    = sipt_pkg::PH_MSG;
						state_d    = sipt_pkg::ST_RUN;
					end else if (item.last) begin
						lanes_d[3] = lanes_base[3] ^ tail_word;
						word_d     = tail_word;
						pw_d       = 56'd0;
						cnt_d      = 8'd0;
						phase_d    = sipt_pkg::PH_TAIL;
						state_d    = sipt_pkg::ST_RUN;
					end
				end
			end
			sipt_pkg::ST_RUN: begin
				lanes_d = hr_out;
				hr_d    = hr_q + 3'd1;
				if (hr_q == hr_end) begin
					hr_d = 3'd0;
					unique case (phase_q)
						sipt_pkg::PH_MSG: begin
							lanes_d[0] = hr_out[0] ^ word_q;
							if (fin_q) begin
								// empty tail after a full block
								lanes_d[3] = hr_out[3] ^ {cnt_q, 56'd0};
								word_d     = {cnt_q, 56'd0};
								cnt_d      = 8'd0;
								phase_d    = sipt_pkg::PH_TAIL;
							end else begin
								state_d = sipt_pkg::ST_IDLE;
							end
						end
						sipt_pkg::PH_TAIL: begin
							lanes_d[0] = hr_out[0] ^ word_q;
							lanes_d[2] = hr_out[2] ^ sipt_pkg::FINAL_XOR;
							phase_d    = sipt_pkg::PH_FINAL;
						end
						sipt_pkg::PH_FINAL: begin
							state_d = sipt_pkg::ST_LAUNCH;
						end
						default: begin
							state_d = sipt_pkg::ST_IDLE;
						end
					endcase
				end
			end
			sipt_pkg::ST_LAUNCH: begin
				fold_ctl.start = 1'b1;
				state_d        = sipt_pkg::ST_FOLD;
			end
			sipt_pkg::ST_FOLD: begin
				if (fold_sts.done) begin
					state_d = sipt_pkg::ST_OUT;
				end
			end
			sipt_pkg::ST_OUT: begin
				if (!out_vld_q || result.ready) begin
					load_out = 1'b1;
					state_d  = sipt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sipt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sipt_pkg::ST_IDLE;
			phase_q   <= sipt_pkg::PH_MSG;
			hr_q      <= 3'd0;
			fin_q     <= 1'b0;
			pw_q      <= 56'd0;
			cnt_q     <= 8'd0;
			in_msg_q  <= 1'b0;
			nonce_q   <= 32'd0;
			out_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			hr_q     <= hr_d;
			fin_q    <= fin_d;
			pw_q     <= pw_d;
			cnt_q    <= cnt_d;
			in_msg_q <= in_msg_d;
			if (cfg.valid && cfg.ready) begin
				nonce_q <= cfg.session_nonce;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lanes_q <= lanes_d;
		word_q  <= word_d;
		if (load_out) begin
			tag_q <= fold_tag;
		end
	end

	assign result.valid = out_vld_q;
	assign result.tag   = tag_q;

	`SIPT_NEVER(a_ready_while_folding, clk, arst_n, fold_sts.busy && item.ready, "ready during fold")
	`SIPT_ASSERT(a_tag_from_out_state, clk, arst_n, $rose(out_vld_q) |-> $past(state_q == sipt_pkg::ST_OUT), "tag without finalization")
	`SIPT_ASSERT(a_last_starts_work, clk, arst_n, (acc && item.last) |=> (state_q == sipt_pkg::ST_RUN), "last word not finalized")
	`SIPT_NEVER(a_short_phase_count, clk, arst_n, state_q == sipt_pkg::ST_RUN && phase_q != sipt_pkg::PH_FINAL && hr_q[2], "block phase overran two rounds")
	`SIPT_ASSERT(a_result_held, clk, arst_n, (out_vld_q && !result.ready) |=> $stable(tag_q), "pending tag overwritten")

endmodule
